>>> sv/ppif_pkg.sv
// Shared types and constants for the prime power in factorial block.
// Holds the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package ppif_pkg;

	localparam int FIELD_BITS = 32;

	typedef struct packed {
		logic load;
		logic step;
		logic acc;
		logic publish;
	} ppif_cmd_t;

	typedef struct packed {
		logic bad;
		logic quo_zero;
	} ppif_stat_t;

endpackage

`default_nettype wire

>>> sv/ppif_datapath.sv
// Datapath: a shared restoring divider, the running sum and the result register.
// Driven by ppif_ctrl through ppif_pkg command and status structs.
// Depends on ppif_pkg.
`default_nettype none

module ppif_datapath #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic [ppif_pkg::FIELD_BITS-1:0] number,
	input  wire logic [ppif_pkg::FIELD_BITS-1:0] base,
	input  wire ppif_pkg::ppif_cmd_t             cmd,
	output ppif_pkg::ppif_stat_t                 stat,
	output logic [ppif_pkg::FIELD_BITS-1:0]      exponent,
	output logic                                 bad_base
);
	import ppif_pkg::*;

	localparam int W    = VALUE_BITS;
	localparam int MAXW = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

	logic [MAXW-1:0]       number_wide;
	logic [MAXW-1:0]       base_wide;
	logic [MAXW-1:0]       total_wide;
	logic [W-1:0]          n_cut;
	logic [W-1:0]          b_cut;
	logic [W-1:0]          quo_q;
	logic [W-1:0]          rem_q;
	logic [W-1:0]          p_q;
	logic [W-1:0]          total_q;
	logic                  bad_q;
	logic [W:0]            r_shift;
	logic [W:0]            p_ext;
	logic [W:0]            diff;
	logic                  ge;
	logic [FIELD_BITS-1:0] exponent_q;
	logic                  bad_base_q;

	assign number_wide = MAXW'(number);
	assign base_wide   = MAXW'(base);
	assign n_cut       = number_wide[W-1:0];
	assign b_cut       = base_wide[W-1:0];
	assign total_wide  = MAXW'(total_q);

	assign r_shift = {rem_q, quo_q[W-1]};
	assign p_ext   = {1'b0, p_q};
	assign ge      = (r_shift >= p_ext);
	assign diff    = r_shift - p_ext;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q   <= n_cut;
			p_q     <= b_cut;
			rem_q   <= '0;
			total_q <= '0;
			bad_q   <= (b_cut[W-1:1] == '0);
		end else if (cmd.step) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : r_shift[W-1:0];
		end else if (cmd.acc) begin
			total_q <= total_q + quo_q;
			rem_q   <= '0;
		end
		if (cmd.publish) begin
			exponent_q <= total_wide[FIELD_BITS-1:0];
			bad_base_q <= bad_q;
		end
	end

	assign stat.bad      = bad_q;
	assign stat.quo_zero = (quo_q == '0);
	assign exponent      = exponent_q;
	assign bad_base      = bad_base_q;

endmodule

`default_nettype wire

>>> sv/ppif_ctrl.sv
// Controller state machine: sequences the divisions and owns both handshakes.
// Issues commands to ppif_datapath and reads its status.
// Depends on ppif_pkg.
`default_nettype none

module ppif_ctrl #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire ppif_pkg::ppif_stat_t stat,
	output ppif_pkg::ppif_cmd_t       cmd
);
	import ppif_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_TEST   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;
	logic             out_valid_q;
	logic             out_free;

	assign cnt_last = (cnt_q == CNT_W'(VALUE_BITS - 1));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = stat.bad ? S_FINISH : S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (cnt_last) begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (stat.quo_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.acc = 1'b1;
					state_d = S_DIV;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK))
		else $error("accepted item did not reach the base check");

	a_bad_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && stat.bad) |=> (state_q == S_FINISH))
		else $error("bad base entered the divider");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_last) |=> (state_q == S_TEST && cnt_q == '0))
		else $error("division did not end after the full bit count");

	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> (out_valid && state_q == S_IDLE))
		else $error("published result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.publish)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> sv/prime_power_in_factorial.sv
// Top level: exponent of a base in the factorial of a number, by Legendre's formula.
// Joins ppif_ctrl and ppif_datapath; depends on ppif_pkg.
//
// Channel  Direction  Handshake             Fields
// in       input      in_valid / in_ready   number[31:0], base[31:0]
// out      output     out_valid / out_ready exponent[31:0], bad_base
//
// A base below 2 goes from the base check straight to the result, skipping the divider.
// Otherwise each quotient n / p^i is formed on the one-bit-a-cycle restoring divider
// and then tested for zero, so an item runs k + 1 divisions in turn,
// with k the number of nonzero quotients (at most VALUE_BITS - 1).
// One item is worked at a time; in_ready is high while the divider is free, even
// with a result still held for out_ready. Reset clears only control state.
`default_nettype none

module prime_power_in_factorial #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ppif_pkg::FIELD_BITS-1:0] number,
	input  wire logic [ppif_pkg::FIELD_BITS-1:0] base,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ppif_pkg::FIELD_BITS-1:0]      exponent,
	output logic                                 bad_base
);
	import ppif_pkg::*;

	ppif_cmd_t  cmd;
	ppif_stat_t stat;

	ppif_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppif_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk     (clk),
		.number  (number),
		.base    (base),
		.cmd     (cmd),
		.stat    (stat),
		.exponent(exponent),
		.bad_base(bad_base)
	);

endmodule

`default_nettype wire
